FILE: src/idia_pkg.sv
// Shared types and constants for the indexed insert/delete array.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package idia_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the word interfaces.
    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 5;
    localparam int VAL_W   = 32;
    localparam int HIT_W   = 4;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;
    localparam int CFG_W   = 5;

    // Derived internal widths.
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_EDIT   = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_GET    = 3'd4,
        MODE_FIND   = 3'd5
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                  we;
        t_mode                 mode;
        logic [CMP_W-1:0]      idx;
        logic [CMP_W-1:0]      count;
        logic [DATA_WIDTH-1:0] word;
    } t_cell_cmd;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic              hit;
        logic [HIT_W-1:0]  hit_index;
        t_status           status;
        logic [ECNT_W-1:0] entry_count;
        logic              full_flag;
        logic              empty_flag;
    } t_result;

endpackage

`default_nettype wire

FILE: src/idia_in_if.sv
// Input word channel of the indexed insert/delete array.
// Depends on idia_pkg for the field widths.
`default_nettype none

interface idia_in_if
    import idia_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot_index;
    logic [VAL_W-1:0]  data_value;

    modport source (output valid, output mode, output slot_index, output data_value,
                    input ready);
    modport sink   (input valid, input mode, input slot_index, input data_value,
                    output ready);
endinterface

`default_nettype wire

FILE: src/idia_out_if.sv
// Result word channel of the indexed insert/delete array.
// Depends on idia_pkg for the field widths.
`default_nettype none

interface idia_out_if
    import idia_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic              hit;
    logic [HIT_W-1:0]  hit_index;
    logic [STAT_W-1:0] status;
    logic [ECNT_W-1:0] entry_count;
    logic              full_flag;
    logic              empty_flag;

    modport source (output valid, output read_value, output hit, output hit_index,
                    output status, output entry_count, output full_flag,
                    output empty_flag, input ready);
    modport sink   (input valid, input read_value, input hit, input hit_index,
                    input status, input entry_count, input full_flag,
                    input empty_flag, output ready);
endinterface

`default_nettype wire

FILE: src/idia_cell.sv
// One storage cell of the array chain: holds one entry, loads, shifts in
// from a neighbor or holds, and reports a match against the search word.
// Depends on idia_pkg.
`default_nettype none

module idia_cell
    import idia_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_cmd             i_cmd,
    input  wire logic [IDX_W-1:0]      i_pos,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_word,
    output logic                       o_match
);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;
    logic [CMP_W-1:0]      pos;
    logic [CMP_W-1:0]      pos_next;

    assign pos      = CMP_W'(i_pos);
    assign pos_next = pos + CMP_W'(1);

    always_comb begin
        n_word = r_word;
        if (i_cmd.we) begin
            case (i_cmd.mode)
                MODE_APPEND: begin
                    if (pos == i_cmd.count) n_word = i_cmd.word;
                end
                MODE_INSERT: begin
                    // Entries from the insert point up to the old end move up one.
                    if (pos == i_cmd.idx) begin
                        n_word = i_cmd.word;
                    end else if (pos > i_cmd.idx && pos <= i_cmd.count) begin
                        n_word = i_left;
                    end
                end
                MODE_EDIT: begin
                    if (pos == i_cmd.idx) n_word = i_cmd.word;
                end
                MODE_DELETE: begin
                    if (pos >= i_cmd.idx && pos_next < i_cmd.count) n_word = i_right;
                end
                default: begin
                    n_word = r_word;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_cmd.word) && (pos < i_cmd.count);

endmodule

`default_nettype wire

FILE: src/indexed_insert_delete_array_core.sv
// Indexed insert/delete array: a chain of DEPTH cells that shift, load and
// compare in parallel, so every operation finishes in the cycle it is accepted.
// Results are registered; throughput is one word per cycle unless the output
// stalls, and the two-deep output register/skid pair takes one more word while
// a result waits. Reset (synchronous, active low) empties the array and sets
// the capacity limit to 16; entry contents are not cleared.
`default_nettype none

module indexed_insert_delete_array_core
    import idia_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    idia_in_if.sink               i_in,
    idia_out_if.source            o_out
);

    logic [CFG_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] eff_cap;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result res;

    logic                  accept;
    logic                  full;
    logic [CMP_W-1:0]      idx;
    logic [CMP_W-1:0]      cnt;
    logic                  we;
    t_status               st;
    logic [DATA_WIDTH-1:0] rd_word;
    logic                  any_hit;
    logic [IDX_W-1:0]      hit_pos;
    t_cell_cmd             cmd;

    logic [DATA_WIDTH-1:0] words   [DEPTH];
    logic [DEPTH-1:0]      match_vec;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = !r_skid_valid;

    // A limit of zero or above the built depth means the whole depth.
    assign eff_cap = (r_cap == '0 || int'(r_cap) > DEPTH) ? CNT_W'(DEPTH)
                                                         : CNT_W'(r_cap);
    assign full = (r_count >= eff_cap);
    assign idx  = CMP_W'(i_in.slot_index);
    assign cnt  = CMP_W'(r_count);

    always_comb begin
        st      = ST_OK;
        we      = 1'b0;
        n_count = r_count;
        rd_word = '0;
        case (t_mode'(i_in.mode))
            MODE_APPEND: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                if (full) begin
                    st = ST_FULL;
                end else if (idx > cnt) begin
                    st = ST_BADIDX;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_EDIT: begin
                if (idx >= cnt) st = ST_BADIDX;
                else            we = 1'b1;
            end
            MODE_DELETE: begin
                if (r_count == '0) begin
                    st = ST_EMPTY;
                end else if (idx >= cnt) begin
                    st = ST_BADIDX;
                end else begin
                    we      = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            MODE_GET: begin
                if (r_count == '0)   st = ST_EMPTY;
                else if (idx >= cnt) st = ST_BADIDX;
                else                 rd_word = words[idx[IDX_W-1:0]];
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    assign cmd.we    = we && accept;
    assign cmd.mode  = t_mode'(i_in.mode);
    assign cmd.idx   = idx;
    assign cmd.count = cnt;
    assign cmd.word  = DATA_WIDTH'(i_in.data_value);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = words[g+1];
        end
        idia_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (IDX_W'(g)),
            .i_left  (left),
            .i_right (right),
            .o_word  (words[g]),
            .o_match (match_vec[g])
        );
    end

    // Lowest matching cell wins.
    always_comb begin
        hit_pos = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (match_vec[k]) hit_pos = IDX_W'(k);
        end
    end
    assign any_hit = (t_mode'(i_in.mode) == MODE_FIND) && (|match_vec);

    assign res.read_value  = VAL_W'(rd_word);
    assign res.hit         = any_hit;
    assign res.hit_index   = any_hit ? HIT_W'(hit_pos) : '0;
    assign res.status      = st;
    assign res.entry_count = ECNT_W'(n_count);
    assign res.full_flag   = (n_count >= eff_cap);
    assign res.empty_flag  = (n_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (accept)   r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !o_out.ready) begin
            if (accept) r_skid_valid <= 1'b1;
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !o_out.ready) begin
            if (accept) r_skid <= res;
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (accept) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_value  = r_out.read_value;
    assign o_out.hit         = r_out.hit;
    assign o_out.hit_index   = r_out.hit_index;
    assign o_out.status      = r_out.status;
    assign o_out.entry_count = r_out.entry_count;
    assign o_out.full_flag   = r_out.full_flag;
    assign o_out.empty_flag  = r_out.empty_flag;

endmodule

`default_nettype wire

FILE: src/idia_checker.sv
// Port-level checks on the result words of the indexed insert/delete array,
// bound to indexed_insert_delete_array_core. Depends on idia_pkg.
`default_nettype none

module idia_checker
    import idia_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              i_ready,
    input wire logic [VAL_W-1:0]  i_read_value,
    input wire logic              i_hit,
    input wire logic [STAT_W-1:0] i_status,
    input wire logic [ECNT_W-1:0] i_entry_count,
    input wire logic              i_empty_flag
);

    // A stalled result word holds until taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_read_value) && $stable(i_status)
                                && $stable(i_entry_count))
        else $error("stalled result word changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_empty_flag == (i_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (int'(i_entry_count) <= DEPTH))
        else $error("entry count above depth");

    // A hit or a read value only comes with an ok status.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_hit || i_read_value != '0) |-> (i_status == STAT_W'(ST_OK)))
        else $error("hit or read data with error status");

endmodule

bind indexed_insert_delete_array_core idia_checker u_idia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_read_value  (o_out.read_value),
    .i_hit         (o_out.hit),
    .i_status      (o_out.status),
    .i_entry_count (o_out.entry_count),
    .i_empty_flag  (o_out.empty_flag)
);

`default_nettype wire

FILE: tb/tb_indexed_insert_delete_array_core.sv
// Self-checking testbench for indexed_insert_delete_array_core: queued command words,
// a shadow array that predicts each result word, and a field-by-field comparison.
// Depends on idia_pkg, idia_in_if, idia_out_if and the core itself.
`timescale 1ns / 100ps

module tb_indexed_insert_delete_array_core;
    import idia_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_WORDS    = 100;
    localparam int MAX_REPORTS    = 10;
    localparam int STALL_CYCLES   = 150;
    localparam int POOL_SIZE      = 8;

    // Mode codes the block treats as no operation.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
    } array_cmd_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    idia_in_if  cmd_ch ();
    idia_out_if res_ch ();

    indexed_insert_delete_array_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    // Shadow copy of the array, its fill count and the capacity register.
    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    int unsigned           shadow_count;
    logic [CFG_W-1:0]      shadow_cap;

    array_cmd_t  pending_cmds[$];
    t_result     expected_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold;
    logic        cmd_stalled = 1'b0;
    int unsigned quiet_cycles = 0;

    int unsigned words_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned find_hits = 0;
    int unsigned refused_ops = 0;
    int unsigned cap_writes = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int unsigned usable_slots(logic [CFG_W-1:0] cap);
        return (cap == 0 || cap > DEPTH) ? DEPTH : 32'(cap);
    endfunction

    function automatic t_result apply_array_cmd(array_cmd_t c);
        t_result               r;
        int unsigned           cap;
        int unsigned           idx;
        int unsigned           i;
        logic [DATA_WIDTH-1:0] word;
        r        = '0;
        r.status = ST_OK;
        cap      = usable_slots(shadow_cap);
        idx      = 32'(c.slot);
        word     = c.value[DATA_WIDTH-1:0];
        case (c.mode)
            MODE_APPEND: begin
                if (shadow_count >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            MODE_INSERT: begin
                // Fullness wins over a bad index; inserting at the count appends.
                if (shadow_count >= cap) begin
                    r.status = ST_FULL;
                end else if (idx > shadow_count) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (i = shadow_count; i > idx; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[idx] = word;
                    shadow_count++;
                end
            end
            MODE_EDIT: begin
                if (idx >= shadow_count)
                    r.status = ST_BADIDX;
                else
                    shadow_words[idx] = word;
            end
            MODE_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (idx >= shadow_count) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (i = idx; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            end
            MODE_GET: begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (idx >= shadow_count)
                    r.status = ST_BADIDX;
                else
                    r.read_value = shadow_words[idx];
            end
            MODE_FIND: begin
                for (i = 0; i < shadow_count; i++) begin
                    if (!r.hit && shadow_words[i] == word) begin
                        r.hit       = 1'b1;
                        r.hit_index = i[HIT_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = shadow_count[ECNT_W-1:0];
        r.full_flag   = (shadow_count >= cap);
        r.empty_flag  = (shadow_count == 0);
        return r;
    endfunction

    function automatic void queue_cmd(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                      logic [VAL_W-1:0] value);
        pending_cmds.push_back('{mode, slot, value});
    endfunction

    // Capacity changes only once every outstanding word has come back.
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        shadow_cap = value;
        cap_writes++;
        @(posedge i_clk);
    endtask

    // Command driver: a word stays on the channel until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_stalled) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd_ch.valid      <= 1'b1;
                cmd_ch.mode       <= pending_cmds[0].mode;
                cmd_ch.slot_index <= pending_cmds[0].slot;
                cmd_ch.data_value <= pending_cmds[0].value;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver; a nonzero hold count forces a long back-pressure stretch.
    always @(negedge i_clk) begin
        if (recv_hold != 0) begin
            res_ch.ready <= 1'b0;
            recv_hold    <= recv_hold - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        array_cmd_t c;
        t_result    want;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                c.mode  = cmd_ch.mode;
                c.slot  = cmd_ch.slot_index;
                c.value = cmd_ch.data_value;
                expected_results.push_back(apply_array_cmd(c));
                pending_cmds.delete(0);
                words_accepted++;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result word with nothing outstanding (status %0d)",
                                 $realtime, res_ch.status);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.hit)
                        find_hits++;
                    if (want.status != ST_OK)
                        refused_ops++;
                    if (res_ch.read_value !== want.read_value || res_ch.hit !== want.hit
                            || res_ch.hit_index !== want.hit_index
                            || res_ch.status !== want.status
                            || res_ch.entry_count !== want.entry_count
                            || res_ch.full_flag !== want.full_flag
                            || res_ch.empty_flag !== want.empty_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: result %0d mismatch", $realtime, results_checked);
                            $display("  expected value %h hit %b at %0d status %0d cnt %0d f%b e%b",
                                     want.read_value, want.hit, want.hit_index, want.status,
                                     want.entry_count, want.full_flag, want.empty_flag);
                            $display("  actual   value %h hit %b at %0d status %0d cnt %0d f%b e%b",
                                     res_ch.read_value, res_ch.hit, res_ch.hit_index,
                                     res_ch.status, res_ch.entry_count, res_ch.full_flag,
                                     res_ch.empty_flag);
                        end
                    end
                end
            end
        end
        cmd_stalled = cmd_ch.valid && !cmd_ch.ready;
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [VAL_W-1:0]  value_pool [POOL_SIZE];
        logic [CFG_W-1:0]  cap_plan [RANDOM_PHASES];
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
        int unsigned       gen_count;
        int unsigned       gen_cap;
        int unsigned       target;
        int unsigned       span;
        int unsigned       pick;

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = '0;
        cmd_ch.slot_index = '0;
        cmd_ch.data_value = '0;
        res_ch.ready      = 1'b0;
        send_idle_pct     = 30;
        recv_idle_pct     = 76;
        recv_hold         = 0;
        shadow_count      = 0;
        shadow_cap        = CAP_RESET;

        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;
        cap_plan = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd16, 5'd2, 5'd2, 5'd16};
        cap_plan[6] = CFG_W'($urandom_range(15, 2));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-array refusals, then insert corners, finds, bad indices, spare modes.
        queue_cmd(MODE_GET,    5'd0,  32'h0);
        queue_cmd(MODE_DELETE, 5'd0,  32'h0);
        queue_cmd(MODE_FIND,   5'd0,  32'h0);
        queue_cmd(MODE_EDIT,   5'd0,  32'h1);
        queue_cmd(MODE_INSERT, 5'd1,  32'h2);
        queue_cmd(MODE_INSERT, 5'd0,  32'hFFFF_FFFF);
        queue_cmd(MODE_APPEND, 5'd0,  32'h0);
        queue_cmd(MODE_INSERT, 5'd2,  32'hA5A5_A5A5);
        queue_cmd(MODE_INSERT, 5'd0,  32'h5A5A_5A5A);
        queue_cmd(MODE_APPEND, 5'd31, 32'h0);
        queue_cmd(MODE_FIND,   5'd0,  32'h0);
        queue_cmd(MODE_FIND,   5'd0,  32'h1234_5678);
        queue_cmd(MODE_GET,    5'd31, 32'h0);
        queue_cmd(MODE_GET,    5'd4,  32'h0);
        queue_cmd(MODE_EDIT,   5'd31, 32'h3);
        queue_cmd(MODE_EDIT,   5'd1,  32'h8000_0001);
        queue_cmd(MODE_DELETE, 5'd5,  32'h0);
        queue_cmd(MODE_DELETE, 5'd0,  32'h0);
        queue_cmd(MODE_DELETE, 5'd3,  32'h0);
        queue_cmd(MODE_INSERT, 5'd31, 32'h4);
        queue_cmd(MODE_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
        queue_cmd(MODE_SPARE_HI, 5'd0,  32'h0);
        queue_cmd(MODE_GET,    5'd0,  32'h0);

        // Capacity dropped below the fill count: growth is refused, entries stay.
        write_capacity(5'd1);
        queue_cmd(MODE_APPEND, 5'd0, 32'h5);
        queue_cmd(MODE_INSERT, 5'd9, 32'h6);
        queue_cmd(MODE_FIND,   5'd0, 32'h8000_0001);
        queue_cmd(MODE_DELETE, 5'd2, 32'h0);
        queue_cmd(MODE_GET,    5'd1, 32'h0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_capacity(cap_plan[p]);
            if (p < 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 76;
            end else if (p < 6) begin
                send_idle_pct = 76;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 6)
                recv_hold = STALL_CYCLES;
            gen_count = shadow_count;
            gen_cap   = usable_slots(cap_plan[p]);
            target    = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // A moving fill target keeps the count sweeping from empty to full.
                if (n % 25 == 0)
                    target = $urandom_range(gen_cap + 2);
                pick = $urandom_range(99);
                if (pick < 3)
                    mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
                else if (pick < 55)
                    mode = (gen_count < target) ?
                           ($urandom_range(1) ? MODE_APPEND : MODE_INSERT) : MODE_DELETE;
                else if (pick < 67)
                    mode = MODE_EDIT;
                else if (pick < 82)
                    mode = MODE_GET;
                else
                    mode = MODE_FIND;
                span  = (mode == MODE_INSERT || gen_count == 0) ? gen_count : gen_count - 1;
                slot  = ($urandom_range(9) < 8) ? SLOT_W'($urandom_range(span))
                                                : SLOT_W'($urandom_range(31));
                value = ($urandom_range(3) == 0) ? $urandom
                                                 : value_pool[$urandom_range(POOL_SIZE - 1)];
                case (mode)
                    MODE_APPEND: if (gen_count < gen_cap) gen_count++;
                    MODE_INSERT: if (gen_count < gen_cap && slot <= gen_count) gen_count++;
                    MODE_DELETE: if (gen_count != 0 && slot < gen_count) gen_count--;
                    default: begin
                    end
                endcase
                queue_cmd(mode, slot, value);
            end
        end

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d command words over %0d capacity writes, with sender/receiver gaps",
                 words_accepted, cap_writes);
        $display("and one long result stall; %0d results checked, %0d find hits, %0d refused.",
                 results_checked, find_hits, refused_ops);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
